// ===== hdl/aeov_pkg.sv =====
// ----------------------------------------------------------------------------
// aeov_pkg
// Shared types and constants for the ACL entry order validator.
// ----------------------------------------------------------------------------
`default_nettype none

package aeov_pkg;

   // width of an entry id word on the request port
   localparam int ENTRY_ID_WIDTH = 32;
   // width of a permission word on the request port
   localparam int PERM_WIDTH     = 32;
   // number of id bits that take part in the order check (8 to 64)
   localparam int ID_BITS        = 32;
   // permission bits that may be set: read, write, execute
   localparam int PERM_OK_BITS   = 3;

   // entry tags, also used as the stage code
   typedef enum logic [2:0] {
      TAG_USER_OBJ  = 3'd0,
      TAG_USER      = 3'd1,
      TAG_GROUP_OBJ = 3'd2,
      TAG_GROUP     = 3'd3,
      TAG_MASK      = 3'd4,
      TAG_OTHER     = 3'd5
   } tag_type;

   localparam logic [2:0] TAG_MAX_VALID = 3'(TAG_OTHER);

   typedef logic [ID_BITS-1:0] id_type;
   typedef logic [1:0]         count_type;

   // saturating two-bit entry counter
   function automatic count_type sat_inc(input count_type c);
      count_type r;
      r = (c == 2'd3) ? c : c + 2'd1;
      return r;
   endfunction

   // keep the low ID_BITS bits of an entry id, zero filled above the port width
   function automatic id_type id_trim(input logic [ENTRY_ID_WIDTH-1:0] id);
      logic [63:0] wide;
      wide = 64'(id);
      return wide[ID_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== hdl/acl_entry_order_validator_core.sv =====
// ----------------------------------------------------------------------------
// acl_entry_order_validator_core
// Checks a sorted access control list streamed one entry per word and
// returns one valid/invalid verdict per list.
// ----------------------------------------------------------------------------
// The block takes one entry word per clock cycle with no gaps needed between
// lists, save that a word ending a list waits while an untaken verdict holds
// the result register. A word is held in an input register; in the next
// cycle the order, id and permission checks run against the list state and
// update it in that same cycle, which is what allows a new word every cycle.
// A word that ends the list (last_entry set, or has_entry clear) loads the
// verdict from the input register into the result register and clears the
// list state for the next list. Words that do not end a list give no result
// and pass even while a verdict waits on the result side.
`default_nettype none

module acl_entry_order_validator_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_ready,
   input  wire logic                                 req_has_entry,
   input  wire logic [2:0]                           req_entry_tag,
   input  wire logic [aeov_pkg::ENTRY_ID_WIDTH-1:0]  req_entry_id,
   input  wire logic [aeov_pkg::PERM_WIDTH-1:0]      req_entry_perm,
   input  wire logic                                 req_last_entry,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   output      logic                                 rsp_list_invalid
);

   // input register
   logic                                 in_valid_ff, in_valid_in;
   logic                                 in_has_ff;
   logic [2:0]                           in_tag_ff;
   logic [aeov_pkg::ENTRY_ID_WIDTH-1:0]  in_id_ff;
   logic [aeov_pkg::PERM_WIDTH-1:0]      in_perm_ff;
   logic                                 in_last_ff;

   // list state
   logic                  err_ff, err_in;
   logic [2:0]            stage_ff, stage_in;
   aeov_pkg::id_type      top_user_ff, top_user_in;
   aeov_pkg::id_type      top_group_ff, top_group_in;
   aeov_pkg::count_type   uo_cnt_ff, uo_cnt_in;
   logic                  any_user_ff, any_user_in;
   aeov_pkg::count_type   go_cnt_ff, go_cnt_in;
   logic                  any_group_ff, any_group_in;
   aeov_pkg::count_type   mask_cnt_ff, mask_cnt_in;
   aeov_pkg::count_type   other_cnt_ff, other_cnt_in;

   // result register
   logic                  out_valid_ff, out_valid_in;
   logic                  out_bad_ff, out_bad_in;

   // check results
   logic                  list_end;
   logic                  out_free;
   logic                  in_go;
   logic                  do_check;
   logic                  perm_bad;
   logic                  tag_bad;
   logic                  id_bad;
   aeov_pkg::id_type      id_now;

   // err / state after this entry, before the end-of-list clear
   logic                  e_err;
   logic [2:0]            e_stage;
   aeov_pkg::id_type      e_top_user, e_top_group;
   aeov_pkg::count_type   e_uo, e_go, e_mask, e_other;
   logic                  e_any_user, e_any_group;

   // handshake
   assign list_end  = !in_has_ff || in_last_ff;
   assign out_free  = !out_valid_ff || rsp_ready;
   assign in_go     = in_valid_ff && (!list_end || out_free);
   assign req_ready = !in_valid_ff || in_go;

   assign rsp_valid        = out_valid_ff;
   assign rsp_list_invalid = out_bad_ff;

   // entry checks
   assign do_check = in_has_ff && !err_ff;
   assign id_now   = aeov_pkg::id_trim(in_id_ff);
   assign perm_bad = |in_perm_ff[aeov_pkg::PERM_WIDTH-1:aeov_pkg::PERM_OK_BITS];
   assign tag_bad  = (in_tag_ff > aeov_pkg::TAG_MAX_VALID) || (stage_ff > in_tag_ff);

   always_comb begin
      id_bad = 1'b0;
      if (in_tag_ff == 3'(aeov_pkg::TAG_USER)) begin
         id_bad = any_user_ff && (id_now <= top_user_ff);
      end else if (in_tag_ff == 3'(aeov_pkg::TAG_GROUP)) begin
         id_bad = any_group_ff && (id_now <= top_group_ff);
      end
   end

   // state update for one entry
   always_comb begin
      e_err       = err_ff;
      e_stage     = stage_ff;
      e_top_user  = top_user_ff;
      e_top_group = top_group_ff;
      e_uo        = uo_cnt_ff;
      e_go        = go_cnt_ff;
      e_mask      = mask_cnt_ff;
      e_other     = other_cnt_ff;
      e_any_user  = any_user_ff;
      e_any_group = any_group_ff;
      if (do_check) begin
         if (perm_bad || tag_bad || id_bad) begin
            e_err = 1'b1;
         end else begin
            unique case (in_tag_ff)
               3'(aeov_pkg::TAG_USER_OBJ): begin
                  e_stage = 3'(aeov_pkg::TAG_USER);
                  e_uo    = aeov_pkg::sat_inc(uo_cnt_ff);
               end
               3'(aeov_pkg::TAG_USER): begin
                  e_stage    = 3'(aeov_pkg::TAG_USER);
                  e_top_user = id_now;
                  e_any_user = 1'b1;
               end
               3'(aeov_pkg::TAG_GROUP_OBJ): begin
                  e_stage = 3'(aeov_pkg::TAG_GROUP);
                  e_go    = aeov_pkg::sat_inc(go_cnt_ff);
               end
               3'(aeov_pkg::TAG_GROUP): begin
                  e_stage     = 3'(aeov_pkg::TAG_GROUP);
                  e_top_group = id_now;
                  e_any_group = 1'b1;
               end
               3'(aeov_pkg::TAG_MASK): begin
                  e_stage = 3'(aeov_pkg::TAG_MASK);
                  e_mask  = aeov_pkg::sat_inc(mask_cnt_ff);
               end
               default: begin
                  e_stage = 3'(aeov_pkg::TAG_OTHER);
                  e_other = aeov_pkg::sat_inc(other_cnt_ff);
               end
            endcase
         end
      end
   end

   // next state: commit the entry, or verdict and clear at list end
   always_comb begin
      in_valid_in  = in_valid_ff;
      err_in       = err_ff;
      stage_in     = stage_ff;
      top_user_in  = top_user_ff;
      top_group_in = top_group_ff;
      uo_cnt_in    = uo_cnt_ff;
      go_cnt_in    = go_cnt_ff;
      mask_cnt_in  = mask_cnt_ff;
      other_cnt_in = other_cnt_ff;
      any_user_in  = any_user_ff;
      any_group_in = any_group_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_bad_in   = out_bad_ff;

      if (in_go) begin
         in_valid_in = 1'b0;
         if (list_end) begin
            out_valid_in = 1'b1;
            out_bad_in   = e_err || (e_uo != 2'd1) || (e_go != 2'd1) ||
                           (e_mask > 2'd1) || (e_other != 2'd1);
            err_in       = 1'b0;
            stage_in     = 3'(aeov_pkg::TAG_USER_OBJ);
            top_user_in  = '0;
            top_group_in = '0;
            uo_cnt_in    = '0;
            go_cnt_in    = '0;
            mask_cnt_in  = '0;
            other_cnt_in = '0;
            any_user_in  = 1'b0;
            any_group_in = 1'b0;
         end else begin
            err_in       = e_err;
            stage_in     = e_stage;
            top_user_in  = e_top_user;
            top_group_in = e_top_group;
            uo_cnt_in    = e_uo;
            go_cnt_in    = e_go;
            mask_cnt_in  = e_mask;
            other_cnt_in = e_other;
            any_user_in  = e_any_user;
            any_group_in = e_any_group;
         end
      end

      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         err_ff       <= 1'b0;
         stage_ff     <= 3'(aeov_pkg::TAG_USER_OBJ);
         top_user_ff  <= '0;
         top_group_ff <= '0;
         uo_cnt_ff    <= '0;
         go_cnt_ff    <= '0;
         mask_cnt_ff  <= '0;
         other_cnt_ff <= '0;
         any_user_ff  <= 1'b0;
         any_group_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         err_ff       <= err_in;
         stage_ff     <= stage_in;
         top_user_ff  <= top_user_in;
         top_group_ff <= top_group_in;
         uo_cnt_ff    <= uo_cnt_in;
         go_cnt_ff    <= go_cnt_in;
         mask_cnt_ff  <= mask_cnt_in;
         other_cnt_ff <= other_cnt_in;
         any_user_ff  <= any_user_in;
         any_group_ff <= any_group_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      out_bad_ff <= out_bad_in;
      if (req_valid && req_ready) begin
         in_has_ff  <= req_has_entry;
         in_tag_ff  <= req_entry_tag;
         in_id_ff   <= req_entry_id;
         in_perm_ff <= req_entry_perm;
         in_last_ff <= req_last_entry;
      end
   end

endmodule

`default_nettype wire
